// ===== rtl/core/ptr_pkg.sv =====
// package for the prescaled timer with reload
// holds shared types, register codes and the threshold table; no dependencies
package ptr_pkg;

  localparam int unsigned ElapsedWidth   = 8;
  localparam int unsigned ByteWidth      = 8;
  localparam int unsigned PrescalerWidth = 9;
  localparam int unsigned SelectWidth    = 2;
  localparam int unsigned ApbAddrWidth   = 4;
  localparam int unsigned ApbDataWidth   = 32;
  localparam int unsigned InDataWidth    = 8;
  localparam int unsigned OutDataWidth   = 24;

  // register index codes (byte address is 4 * index)
  typedef enum logic [1:0] {
    REG_TIMER_ENABLE = 2'd0,
    REG_CLOCK_SELECT = 2'd1,
    REG_RELOAD_VALUE = 2'd2,
    REG_UNUSED       = 2'd3
  } ptr_reg_idx_t;

  // configuration seen by the tick datapath
  typedef struct packed {
    logic                   timer_enable;
    logic [SelectWidth-1:0] clock_select;
    logic [ByteWidth-1:0]   reload_value;
  } ptr_cfg_t;

  // one result item
  typedef struct packed {
    logic                 timer_irq;
    logic                 counter_stepped;
    logic [ByteWidth-1:0] counter_value;
    logic [ByteWidth-1:0] divider_value;
  } ptr_result_t;

  // prescaler threshold for each clock select code
  function automatic logic [PrescalerWidth-1:0] threshold_of(
    input logic [SelectWidth-1:0] sel
  );
    logic [PrescalerWidth-1:0] thr;
    case (sel)
      2'd0:    thr = 9'd255;
      2'd1:    thr = 9'd3;
      2'd2:    thr = 9'd15;
      default: thr = 9'd63;
    endcase
    return thr;
  endfunction

endpackage

// ===== rtl/core/prescaled_timer_with_reload.sv =====
// top level of the prescaled timer with reload
// depends on ptr_pkg, ptr_cfg_regs, ptr_tick_core, ptr_out_stage
//
// Each input item reports the machine cycles elapsed since the previous one and
// yields exactly one result item with the divider and counter bytes after that
// tick, a step flag and the timer interrupt flag. The state update is a single
// add and compare ahead of the result register, so one item is taken every cycle
// while the output is being taken; the input stalls only while a finished result
// waits at the output. Registers sit at byte addresses 0 (timer_enable),
// 4 (clock_select) and 8 (reload_value); the user must write them only while no
// item is in flight, and the block itself does not enforce this.
module prescaled_timer_with_reload
  import ptr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // tdata: [7:0] elapsed_cycles
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [InDataWidth-1:0]  s_tdata,
  // tdata: [7:0] divider_value, [15:8] counter_value, [16] counter_stepped,
  // [17] timer_irq, [23:18] zero
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OutDataWidth-1:0] m_tdata,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready
);

  ptr_cfg_t    cfg;
  ptr_result_t result;
  logic        out_busy;
  logic        take;

  assign s_tready = !out_busy;
  assign take     = s_tvalid && s_tready;

  ptr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptr_tick_core u_core (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .elapsed_cycles (s_tdata[ElapsedWidth-1:0]),
    .cfg            (cfg),
    .result         (result)
  );

  ptr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .result   (result),
    .out_busy (out_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/core/ptr_cfg_regs.sv =====
// configuration registers of the prescaled timer behind an apb-style port
// depends on ptr_pkg
module ptr_cfg_regs
  import ptr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  output ptr_cfg_t                cfg
);

  ptr_cfg_t     cfg_next;
  ptr_reg_idx_t reg_idx;
  logic         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = ptr_reg_idx_t'(paddr[ApbAddrWidth-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // write decode
  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TIMER_ENABLE: cfg_next.timer_enable = pwdata[0];
        REG_CLOCK_SELECT: cfg_next.clock_select = pwdata[SelectWidth-1:0];
        REG_RELOAD_VALUE: cfg_next.reload_value = pwdata[ByteWidth-1:0];
        default:          cfg_next = cfg;
      endcase
    end
  end

  // register state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TIMER_ENABLE: prdata[0] = cfg.timer_enable;
      REG_CLOCK_SELECT: prdata[SelectWidth-1:0] = cfg.clock_select;
      REG_RELOAD_VALUE: prdata[ByteWidth-1:0] = cfg.reload_value;
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/ptr_tick_core.sv =====
// timer state (divider, counter, prescaler, last select) and its per-tick update
// depends on ptr_pkg
module ptr_tick_core
  import ptr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [ElapsedWidth-1:0] elapsed_cycles,
  input  ptr_cfg_t                cfg,
  output ptr_result_t             result
);

  logic [ByteWidth-1:0]      divider, divider_next;
  logic [ByteWidth-1:0]      counter, counter_next;
  logic [PrescalerWidth-1:0] prescaler, prescaler_next;
  logic [SelectWidth-1:0]    last_select, last_select_next;

  logic [PrescalerWidth-1:0] pre_base;
  logic [PrescalerWidth-1:0] pre_sum;
  logic                      reached;
  logic                      wrap;

  // next state for one tick
  always_comb begin
    pre_base = (cfg.clock_select != last_select) ? '0 : prescaler;
    pre_sum  = pre_base + PrescalerWidth'(elapsed_cycles);
    reached  = (pre_sum >= threshold_of(cfg.clock_select));
    wrap     = (counter == {ByteWidth{1'b1}});

    divider_next     = divider;
    counter_next     = counter;
    prescaler_next   = prescaler;
    last_select_next = last_select;

    if (cfg.timer_enable) begin
      last_select_next = cfg.clock_select;
      divider_next     = divider + elapsed_cycles;
      prescaler_next   = reached ? '0 : pre_sum;
      if (reached) begin
        counter_next = wrap ? cfg.reload_value : counter + 8'd1;
      end
    end

    result.divider_value   = divider_next;
    result.counter_value   = counter_next;
    result.counter_stepped = cfg.timer_enable && reached;
    result.timer_irq       = cfg.timer_enable && reached && wrap;
  end

  // state registers, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      divider     <= '0;
      counter     <= '0;
      prescaler   <= '0;
      last_select <= '0;
    end else if (take) begin
      divider     <= divider_next;
      counter     <= counter_next;
      prescaler   <= prescaler_next;
      last_select <= last_select_next;
    end
  end

endmodule

// ===== rtl/core/ptr_out_stage.sv =====
// result register between the tick datapath and the output stream
// depends on ptr_pkg
module ptr_out_stage
  import ptr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  ptr_result_t             result,
  output logic                    out_busy,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OutDataWidth-1:0] m_tdata
);

  ptr_result_t held;

  // blocks new items only while a result waits and is not taken
  assign out_busy = m_tvalid && !m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      held <= result;
    end
  end

  assign m_tdata = {{(OutDataWidth - $bits(ptr_result_t)){1'b0}}, held};

endmodule

// ===== rtl/core/ptr_checker.sv =====
// port-level checks for the prescaled timer with reload, bound to the top level
// depends on ptr_pkg and prescaled_timer_with_reload
module ptr_checker
  import ptr_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [OutDataWidth-1:0] m_tdata,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite,
  input logic [ApbAddrWidth-1:0] paddr,
  input logic [ApbDataWidth-1:0] pwdata,
  input logic                    pready
);

  logic en_shadow;
  logic s_take;

  assign s_take = s_tvalid && s_tready;

  // track the enable bit from the write traffic
  always_ff @(posedge clk) begin
    if (rst) begin
      en_shadow <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ApbAddrWidth-1:2] == REG_TIMER_ENABLE) begin
      en_shadow <= pwdata[0];
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // every accepted item shows a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_take |=> m_tvalid)
    else $error("accepted item produced no result");

  // interrupt only comes with a counter step
  a_irq_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[17] && !m_tdata[16]))
    else $error("interrupt without counter step");

  // a tick while disabled never steps the counter
  a_disabled: assert property (@(posedge clk) disable iff (rst)
    s_take && !en_shadow |=> !m_tdata[16] && !m_tdata[17])
    else $error("disabled tick stepped the counter");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind prescaled_timer_with_reload ptr_checker u_ptr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .pready   (pready)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for prescaled_timer_with_reload
// predicts divider, counter, step and interrupt per tick item; depends on ptr_pkg and the rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ptr_pkg::*;

  // clock select codes and their prescaler thresholds
  localparam logic [SelectWidth-1:0] SelDiv256 = 2'd0;
  localparam logic [SelectWidth-1:0] SelDiv4   = 2'd1;
  localparam logic [SelectWidth-1:0] SelDiv16  = 2'd2;
  localparam logic [SelectWidth-1:0] SelDiv64  = 2'd3;

  localparam int Segments     = 8;
  localparam int SegmentItems = 50;
  localparam int QuietLimit   = 2000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  // tdata: [7:0] elapsed_cycles
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  // tdata: [7:0] divider_value, [15:8] counter_value, [16] counter_stepped,
  // [17] timer_irq, [23:18] zero
  logic [OutDataWidth-1:0] m_tdata;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ApbAddrWidth-1:0] paddr = '0;
  logic [ApbDataWidth-1:0] pwdata = '0;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  // timer registers as the predictor sees them
  logic                      tmr_enable;
  logic [SelectWidth-1:0]    tmr_select;
  logic [ByteWidth-1:0]      reload_byte;
  // predicted timer state
  logic [ByteWidth-1:0]      div_byte;
  logic [ByteWidth-1:0]      cnt_byte;
  logic [PrescalerWidth-1:0] presc;
  logic [SelectWidth-1:0]    seen_select;

  ptr_result_t expected_ticks[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;

  prescaled_timer_with_reload u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // random backpressure on the result side
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic logic [PrescalerWidth-1:0] step_limit(input logic [SelectWidth-1:0] sel);
    case (sel)
      SelDiv256: return 9'd255;
      SelDiv4:   return 9'd3;
      SelDiv16:  return 9'd15;
      default:   return 9'd63;
    endcase
  endfunction

  // advance the predicted timer by one tick and return the result it gives
  function automatic ptr_result_t advance_timer(input logic [ElapsedWidth-1:0] cyc);
    ptr_result_t r;
    r = '0;
    if (tmr_enable) begin
      if (tmr_select != seen_select) begin
        seen_select = tmr_select;
        presc = '0;
      end
      div_byte = div_byte + cyc;
      presc = presc + {1'b0, cyc};
      if (presc >= step_limit(tmr_select)) begin
        presc = '0;
        r.counter_stepped = 1'b1;
        if (cnt_byte == 8'hFF) begin
          cnt_byte = reload_byte;
          r.timer_irq = 1'b1;
        end else begin
          cnt_byte = cnt_byte + 8'd1;
        end
      end
    end
    r.divider_value = div_byte;
    r.counter_value = cnt_byte;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // register writes, result checks, tick prediction and watchdog
  always @(posedge clk) begin
    ptr_result_t got;
    ptr_result_t want;
    if (rst) begin
      tmr_enable  = 1'b0;
      tmr_select  = SelDiv256;
      reload_byte = '0;
      div_byte    = '0;
      cnt_byte    = '0;
      presc       = '0;
      seen_select = SelDiv256;
      quiet_cycles = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ptr_reg_idx_t'(paddr[3:2]))
          REG_TIMER_ENABLE: tmr_enable  = pwdata[0];
          REG_CLOCK_SELECT: tmr_select  = pwdata[SelectWidth-1:0];
          REG_RELOAD_VALUE: reload_byte = pwdata[ByteWidth-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = ptr_result_t'(m_tdata[17:0]);
        if (expected_ticks.size() == 0) begin
          $error("result item with no tick waiting: tdata 0x%06h", m_tdata);
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("divider_value", 32'(want.divider_value),
                      32'(got.divider_value));
          check_field("counter_value", 32'(want.counter_value),
                      32'(got.counter_value));
          check_field("counter_stepped", 32'(want.counter_stepped),
                      32'(got.counter_stepped));
          check_field("timer_irq", 32'(want.timer_irq), 32'(got.timer_irq));
        end
        check_field("tdata padding", 0, 32'(m_tdata[OutDataWidth-1:18]));
      end
      if (s_tvalid && s_tready) begin
        expected_ticks.push_back(advance_timer(s_tdata));
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // offer one tick item, with a random gap first, and wait until it is taken
  task automatic send_tick(input logic [ElapsedWidth-1:0] cyc);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cyc;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering items and let every outstanding result drain
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup cycle, access cycle, then the bus returns to idle
  task automatic write_reg(input ptr_reg_idx_t idx, input logic [ApbDataWidth-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timer(input logic en, input logic [SelectWidth-1:0] sel,
                           input logic [ByteWidth-1:0] reload);
    quiesce();
    write_reg(REG_TIMER_ENABLE, ApbDataWidth'(en));
    write_reg(REG_CLOCK_SELECT, ApbDataWidth'(sel));
    write_reg(REG_RELOAD_VALUE, ApbDataWidth'(reload));
  endtask

  // disabled after reset: nothing moves, not even the divider
  task automatic test_disabled_ticks();
    send_tick(8'd0);
    send_tick(8'd255);
    send_tick(8'd7);
  endtask

  // fast mode: exact threshold, accumulation, and excess thrown away
  task automatic test_prescaler_steps();
    set_timer(1'b1, SelDiv4, 8'hA5);
    send_tick(8'd0);
    send_tick(8'd2);
    send_tick(8'd1);
    send_tick(8'd3);
    send_tick(8'd255);
    send_tick(8'd1);
    send_tick(8'd1);
  endtask

  // a new select clears the prescaler before the tick adds in
  task automatic test_select_change();
    quiesce();
    write_reg(REG_CLOCK_SELECT, ApbDataWidth'(SelDiv16));
    send_tick(8'd14);
    send_tick(8'd1);
    quiesce();
    write_reg(REG_CLOCK_SELECT, ApbDataWidth'(SelDiv256));
    send_tick(8'd254);
    send_tick(8'd1);
    quiesce();
    write_reg(REG_CLOCK_SELECT, ApbDataWidth'(SelDiv64));
    send_tick(8'd63);
    send_tick(8'd40);
  endtask

  // select changed while disabled only takes effect on the next enabled tick
  task automatic test_disable_hold();
    set_timer(1'b0, SelDiv16, 8'hFF);
    send_tick(8'd200);
    quiesce();
    write_reg(REG_TIMER_ENABLE, ApbDataWidth'(1'b1));
    send_tick(8'd20);
    send_tick(8'd255);
  endtask

  function automatic logic [ElapsedWidth-1:0] pick_elapsed(input logic [SelectWidth-1:0] sel);
    int v;
    case ($urandom_range(9))
      0, 1: v = $urandom_range(4);
      2, 3: v = int'(step_limit(sel)) - 2 + int'($urandom_range(4));
      4:    v = $urandom_range(1) ? 255 : 0;
      default: v = $urandom_range(255);
    endcase
    if (v > 255) v = 255;
    return v[ElapsedWidth-1:0];
  endfunction

  // random settings per segment, random tick sizes, given idling mix
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    logic                   en;
    logic [SelectWidth-1:0] sel;
    logic [ByteWidth-1:0]   reload;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    for (int seg = 0; seg < Segments; seg++) begin
      en  = ($urandom_range(99) < 85);
      sel = SelectWidth'($urandom_range(3));
      case ($urandom_range(3))
        0: reload = 8'h00;
        1: reload = 8'hFF;
        2: reload = ByteWidth'($urandom_range(255, 240));
        default: reload = ByteWidth'($urandom_range(255));
      endcase
      set_timer(en, sel, reload);
      for (int i = 0; i < SegmentItems; i++) begin
        send_tick(pick_elapsed(sel));
      end
    end
    quiesce();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
  endtask

  initial begin
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_ticks();
    test_prescaler_steps();
    test_select_change();
    test_disable_hold();
    test_random_traffic(0, 0);
    test_random_traffic(67, 0);
    test_random_traffic(0, 67);
    test_random_traffic(25, 25);

    quiesce();
    repeat (8) @(posedge clk);
    if (expected_ticks.size() != 0) begin
      $error("%0d tick results never arrived", expected_ticks.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ptr_pkg.sv
rtl/core/ptr_cfg_regs.sv
rtl/core/ptr_tick_core.sv
rtl/core/ptr_out_stage.sv
rtl/core/prescaled_timer_with_reload.sv
rtl/core/ptr_checker.sv
tb/tb_top.sv
